/* hw/rtl/qaa_pkg.sv */
`default_nettype none
package qaa_pkg;

    localparam int SIDE_LOG2_DEF   = 10;
    localparam int TREE_LEVELS_DEF = 5;

    // Fixed field widths of the request and response items.
    localparam int SIDE_W = 11;
    localparam int POS_W  = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_NEXT,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Number of tiles over all levels: 1 + 4 + 16 + ...
    function automatic int tile_count(input int levels);
        int sum;
        sum = 0;
        for (int k = 0; k < levels; k++)
        begin
            sum = sum + (1 << (2 * k));
        end
        return sum;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/qaa_req_if.sv */
`default_nettype none
interface qaa_req_if;
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic [qaa_pkg::SIDE_W-1:0] req_side;

    modport source (output valid, output operation, output req_side, input ready);
    modport sink   (input valid, input operation, input req_side, output ready);
endinterface
`default_nettype wire

/* hw/rtl/qaa_rsp_if.sv */
`default_nettype none
interface qaa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [qaa_pkg::POS_W-1:0]  pos_x;
    logic [qaa_pkg::POS_W-1:0]  pos_y;
    logic [qaa_pkg::SIDE_W-1:0] width;
    logic [qaa_pkg::SIDE_W-1:0] height;

    modport source (output valid, output ok, output pos_x, output pos_y,
                    output width, output height, input ready);
    modport sink   (input valid, input ok, input pos_x, input pos_y,
                    input width, input height, output ready);
endinterface
`default_nettype wire

/* hw/rtl/qaa_ram.sv */
`default_nettype none
module qaa_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 341
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* hw/rtl/quadtree_atlas_allocator.sv */
`default_nettype none
// Quadtree texture atlas allocator. A square atlas 2^SIDE_LOG2 texels wide is
// split into TREE_LEVELS levels of square tiles whose blocking marks live in
// one synchronous RAM, level by level. An allocate item rounds its side up to
// a power of two, walks the tree depth first in Z-order and takes the first
// free tile at the matching level; a clear item zeroes every mark. Items are
// handled one at a time. An allocate is accepted in idle, then for each tile
// it visits reads the RAM and then checks the mark, takes a step to the next
// sibling or back out for each tile it passes over or has tried the children
// of, writes the marks of the taken tile and its ancestors on success and
// hands over the result. The worst case with defaults is a search over all
// 340 tiles below the root. A clear, and the pass that runs right after reset,
// writes every one of the tile_count(TREE_LEVELS) entries at one per cycle
// (341 entries with defaults) before the block takes an item. A finished
// result sits in an output register, so the response side may stall without
// losing anything.
module quadtree_atlas_allocator #(
    parameter int SIDE_LOG2   = qaa_pkg::SIDE_LOG2_DEF,
    parameter int TREE_LEVELS = qaa_pkg::TREE_LEVELS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    qaa_req_if.sink   req,
    qaa_rsp_if.source rsp
);

    localparam int TILES = qaa_pkg::tile_count(TREE_LEVELS);
    localparam int IDX_W = $clog2(TILES);
    localparam int LV_W  = $clog2(TREE_LEVELS + 1);
    localparam int NL    = TREE_LEVELS - 1;

    localparam logic [LV_W-1:0] FULL_MARK = LV_W'(TREE_LEVELS);

    qaa_pkg::state_t state_reg, state_next;

    logic [LV_W-1:0]  lvl_reg, lvl_next;
    logic [LV_W-1:0]  want_reg, want_next;
    logic [1:0]       dig_reg [NL];
    logic [1:0]       dig_next [NL];
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_reply_reg, clr_reply_next;

    logic                       res_ok_reg, res_ok_next;
    logic [qaa_pkg::POS_W-1:0]  res_x_reg, res_x_next;
    logic [qaa_pkg::POS_W-1:0]  res_y_reg, res_y_next;
    logic [qaa_pkg::SIDE_W-1:0] side_reg, side_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_ok_reg, out_ok_next;
    logic [qaa_pkg::POS_W-1:0]  out_x_reg, out_x_next;
    logic [qaa_pkg::POS_W-1:0]  out_y_reg, out_y_next;
    logic [qaa_pkg::SIDE_W-1:0] out_side_reg, out_side_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [LV_W-1:0]  ram_wdata;
    logic [LV_W-1:0]  ram_rdata;

    logic [IDX_W-1:0] cur_idx;
    logic [31:0]      pos_x_full;
    logic [31:0]      pos_y_full;
    logic [LV_W-1:0]  dec_want;
    logic             dec_fail;

    qaa_ram #(
        .WIDTH (LV_W),
        .DEPTH (TILES)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Entry of the tile on the current path at level lvl_reg: the level's
    // base plus the path digits of levels 1..lvl_reg read as base-4 number.
    always_comb
    begin
        int base;
        int tile;
        base = 0;
        tile = 0;
        for (int k = 0; k < TREE_LEVELS; k++)
        begin
            if (k < int'(lvl_reg))
            begin
                base = base + (1 << (2 * k));
            end
        end
        for (int k = 0; k < NL; k++)
        begin
            if (k + 1 <= int'(lvl_reg))
            begin
                tile = (tile << 2) | int'(dig_reg[k]);
            end
        end
        cur_idx = IDX_W'(base + tile);
    end

    // Texel position of the tile on the path at level lvl_reg. Levels finer
    // than one texel count as one texel wide.
    always_comb
    begin
        int sx;
        int sy;
        int sd;
        sx = 0;
        sy = 0;
        for (int k = 0; k < NL; k++)
        begin
            sd = (k + 1 < SIDE_LOG2) ? (1 << (SIDE_LOG2 - k - 1)) : 1;
            if (k + 1 <= int'(lvl_reg))
            begin
                if (dig_reg[k][0])
                begin
                    sx = sx + sd;
                end
                if (dig_reg[k][1])
                begin
                    sy = sy + sd;
                end
            end
        end
        pos_x_full = 32'(sx);
        pos_y_full = 32'(sy);
    end

    // Request decode: round the side up to a power of two and map it to a
    // level, clamped to the deepest one. Zero, oversized and whole-atlas
    // requests fail at once.
    always_comb
    begin
        int lg;
        int wv;
        lg = qaa_pkg::SIDE_W;
        for (int k = qaa_pkg::SIDE_W - 1; k >= 0; k--)
        begin
            if ((12'd1 << k) >= {1'b0, req.req_side})
            begin
                lg = k;
            end
        end
        wv = SIDE_LOG2 - lg;
        if (wv > NL)
        begin
            wv = NL;
        end
        dec_fail = (req.req_side == '0) || (lg > SIDE_LOG2) || (wv <= 0);
        dec_want = dec_fail ? '0 : LV_W'(wv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qaa_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        want_reg     <= want_next;
        dig_reg      <= dig_next;
        res_ok_reg   <= res_ok_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        side_reg     <= side_next;
        out_ok_reg   <= out_ok_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_side_reg <= out_side_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        want_next      = want_reg;
        dig_next       = dig_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        res_ok_next    = res_ok_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        side_next      = side_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_side_next  = out_side_reg;
        ram_we         = 1'b0;
        ram_addr       = cur_idx;
        ram_wdata      = '0;
        req.ready      = 1'b0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            qaa_pkg::ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
                if (clr_cnt_reg == IDX_W'(TILES - 1))
                begin
                    clr_cnt_next = '0;
                    res_ok_next  = 1'b1;
                    res_x_next   = '0;
                    res_y_next   = '0;
                    side_next    = '0;
                    state_next   = clr_reply_reg ? qaa_pkg::ST_DONE : qaa_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            qaa_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    res_ok_next = 1'b0;
                    res_x_next  = '0;
                    res_y_next  = '0;
                    side_next   = req.req_side;
                    want_next   = dec_want;
                    lvl_next    = LV_W'(1);
                    dig_next[0] = 2'd0;
                    if (req.operation == qaa_pkg::OP_CLEAR)
                    begin
                        clr_reply_next = 1'b1;
                        state_next     = qaa_pkg::ST_CLEAR;
                    end
                    else if (dec_fail)
                    begin
                        state_next = qaa_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = qaa_pkg::ST_READ;
                    end
                end
            end

            qaa_pkg::ST_READ:
            begin
                state_next = qaa_pkg::ST_CHECK;
            end

            qaa_pkg::ST_CHECK:
            begin
                if (want_reg < ram_rdata)
                begin
                    state_next = qaa_pkg::ST_NEXT;
                end
                else if (lvl_reg == want_reg)
                begin
                    res_ok_next = 1'b1;
                    res_x_next  = pos_x_full[qaa_pkg::POS_W-1:0];
                    res_y_next  = pos_y_full[qaa_pkg::POS_W-1:0];
                    state_next  = qaa_pkg::ST_WRITE;
                end
                else
                begin
                    for (int k = 0; k < NL; k++)
                    begin
                        if (k == int'(lvl_reg))
                        begin
                            dig_next[k] = 2'd0;
                        end
                    end
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = qaa_pkg::ST_READ;
                end
            end

            // Move to the next sibling, climbing while the last corner of a
            // tile has been tried.
            qaa_pkg::ST_NEXT:
            begin
                for (int k = 0; k < NL; k++)
                begin
                    if (k + 1 == int'(lvl_reg))
                    begin
                        if (dig_reg[k] == 2'd3)
                        begin
                            if (lvl_reg == LV_W'(1))
                            begin
                                state_next = qaa_pkg::ST_DONE;
                            end
                            else
                            begin
                                lvl_next = lvl_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            dig_next[k] = dig_reg[k] + 2'd1;
                            state_next  = qaa_pkg::ST_READ;
                        end
                    end
                end
            end

            // Mark the taken tile full, then every ancestor up to the root.
            qaa_pkg::ST_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = (lvl_reg == want_reg) ? FULL_MARK : want_reg;
                if (lvl_reg == '0)
                begin
                    state_next = qaa_pkg::ST_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end

            qaa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_side_next  = res_ok_reg ? side_reg : '0;
                    clr_reply_next = 1'b0;
                    state_next     = qaa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = qaa_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.ok     = out_ok_reg;
    assign rsp.pos_x  = out_x_reg;
    assign rsp.pos_y  = out_y_reg;
    assign rsp.width  = out_side_reg;
    assign rsp.height = out_side_reg;

    // The mark store is only written by the clearing pass and the commit.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == qaa_pkg::ST_CLEAR || state_reg == qaa_pkg::ST_WRITE))
        else $error("mark store written outside clear or commit");

    // The search never runs at the root level or below the requested level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qaa_pkg::ST_READ || state_reg == qaa_pkg::ST_CHECK)
        |-> (lvl_reg != '0 && lvl_reg <= want_reg))
        else $error("search level out of range");

    // A failed response carries no position or size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ok) |-> (rsp.pos_x == '0 && rsp.pos_y == '0 && rsp.width == '0))
        else $error("failed response with nonzero fields");

    // An accepted item always moves the block out of idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != qaa_pkg::ST_IDLE))
        else $error("accepted item left the block idle");

endmodule
`default_nettype wire
